// File: hw/rtl/assert_macros.svh
// Assertion helpers for the point-pair distance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that ante at one edge implies cons at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/nppd_pkg.sv
// ---------------------------------------------------------------------------
// nppd_pkg
// Shared types and constants of the point-pair distance block.
// ---------------------------------------------------------------------------
package nppd_pkg;

  localparam int VTX_BITS   = 8;
  localparam int SEG_BITS   = 9;
  localparam int COORD_BITS = 24;
  localparam int DIST_BITS  = 32;
  localparam int CNT_BITS   = 16;
  localparam int PATH_ABITS = 2 * VTX_BITS;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * DIFF_BITS + 2;
  localparam int ROOT_BITS  = (SQ_BITS + 1) / 2;
  localparam int SUM_BITS   = DIST_BITS + 2;

  typedef enum logic [1:0] {
    MODE_VERTEX = 2'd0,
    MODE_SEGMENT = 2'd1,
    MODE_PATH = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  // Leg selection for the shared root unit.
  typedef enum logic [1:0] {
    LEG_P1 = 2'd0,
    LEG_P2 = 2'd1,
    LEG_Q1 = 2'd2,
    LEG_Q2 = 2'd3
  } leg_t;

  typedef struct packed {
    logic  cap;        // capture query
    logic  wr_vertex;
    logic  wr_segment;
    logic  wr_path;
    logic  seg_rd;     // read segment stores
    logic  vtx_rd;     // read vertex for leg
    leg_t  vtx_leg;
    logic  leg_start;  // start root with vertex or same-segment points
    logic  leg_direct; // same segment: use query points
    logic  leg_save;   // store finished root
    leg_t  save_leg;
    logic  path_rd;
    logic [1:0] path_sel;
    logic  path_save;
    logic  sum_step;
    logic  result_load;
  } cmd_t;

  typedef struct packed {
    logic same;
    logic root_done;
  } stat_t;

endpackage

// File: hw/rtl/nppd_ram.sv
// ---------------------------------------------------------------------------
// nppd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module nppd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/nppd_sqrt.sv
// ---------------------------------------------------------------------------
// nppd_sqrt
// Squared distance and bit-serial integer square root, one result bit a cycle.
// ---------------------------------------------------------------------------
module nppd_sqrt
  import nppd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  output logic                         done,
  output logic [ROOT_BITS-1:0]         root
);

  localparam int STEP_BITS = $clog2(ROOT_BITS + 2);

  typedef enum logic [1:0] {S_IDLE, S_SQUARE, S_SUM, S_ITER} sq_state_t;

  sq_state_t             state;
  logic [DIFF_BITS-1:0]  dx, dy;
  logic [SQ_BITS-1:0]    sqx, sqy, rem;
  logic [ROOT_BITS-1:0]  res;
  logic [STEP_BITS-1:0]  step;
  logic [ROOT_BITS+1:0]  trial;
  logic [ROOT_BITS+1:0]  top;
  logic signed [DIFF_BITS-1:0] ddx, ddy;

  assign ddx = DIFF_BITS'(ax) - DIFF_BITS'(bx);
  assign ddy = DIFF_BITS'(ay) - DIFF_BITS'(by);

  // Restoring root: bring in two bits of the radicand per step.
  assign top   = {rem[ROOT_BITS-1:0], 2'b00} |
                 (ROOT_BITS+2)'(sqx[SQ_BITS-1 -: 2]);
  assign trial = {res, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            dx <= ddx[DIFF_BITS-1] ? DIFF_BITS'(-ddx) : DIFF_BITS'(ddx);
            dy <= ddy[DIFF_BITS-1] ? DIFF_BITS'(-ddy) : DIFF_BITS'(ddy);
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          sqx <= SQ_BITS'(dx * dx);
          sqy <= SQ_BITS'(dy * dy);
          state <= S_SUM;
        end
        S_SUM: begin
          sqx <= sqx + sqy;
          rem <= '0;
          res <= '0;
          step <= '0;
          state <= S_ITER;
        end
        S_ITER: begin
          if (top >= trial) begin
            rem <= SQ_BITS'(top - trial);
            res <= {res[ROOT_BITS-2:0], 1'b1};
          end else begin
            rem <= SQ_BITS'(top);
            res <= {res[ROOT_BITS-2:0], 1'b0};
          end
          sqx  <= {sqx[SQ_BITS-3:0], 2'b00};
          step <= step + 1'b1;
          if (step == STEP_BITS'(ROOT_BITS - 1)) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign root = res;

endmodule

// File: hw/rtl/nppd_datapath.sv
// ---------------------------------------------------------------------------
// nppd_datapath
// Stores, query registers, leg roots and the four-way path minimum.
// ---------------------------------------------------------------------------
module nppd_datapath
  import nppd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  logic [SEG_BITS-1:0]          entry_index,
  input  logic [VTX_BITS-1:0]          vertex_from,
  input  logic [VTX_BITS-1:0]          vertex_to,
  input  logic [DIST_BITS-1:0]         path_value,
  input  logic signed [COORD_BITS-1:0] x_first,
  input  logic signed [COORD_BITS-1:0] y_first,
  input  logic [SEG_BITS-1:0]          seg_first,
  input  logic signed [COORD_BITS-1:0] x_second,
  input  logic signed [COORD_BITS-1:0] y_second,
  input  logic [SEG_BITS-1:0]          seg_second,
  output logic [DIST_BITS-1:0]         res_distance,
  output logic                         res_saturated
);

  logic signed [COORD_BITS-1:0] xp, yp, xq, yq;
  logic [SEG_BITS-1:0]          sp, sq;
  logic [VTX_BITS-1:0]          p1, p2, q1, q2;
  logic [VTX_BITS-1:0]          sp_s, sp_e, sq_s, sq_e;
  logic [VTX_BITS-1:0]          vaddr;
  logic [COORD_BITS-1:0]        vx_rd, vy_rd;
  logic [ROOT_BITS-1:0]         root;
  logic                         root_done;
  logic [ROOT_BITS-1:0]         leg_r [4];
  logic [PATH_ABITS-1:0]        praddr;
  logic [DIST_BITS-1:0]         prd;
  logic [DIST_BITS-1:0]         pth [4];
  logic [1:0]                   sum_idx;
  logic [SUM_BITS+2:0]          best;
  logic [SUM_BITS+2:0]          cand;
  logic                         same_leg_sel;
  logic signed [COORD_BITS-1:0] sax, say, sbx, sby;
  logic [1:0]                   lg;
  logic                         vtx_we;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      xp <= x_first;  yp <= y_first;  sp <= seg_first;
      xq <= x_second; yq <= y_second; sq <= seg_second;
    end
  end

  nppd_ram #(.WIDTH(VTX_BITS), .DEPTH(1 << SEG_BITS)) u_seg_s0 (
    .clk, .we(cmd.wr_segment), .waddr(entry_index), .wdata(vertex_from),
    .raddr(sp), .rdata(sp_s));
  nppd_ram #(.WIDTH(VTX_BITS), .DEPTH(1 << SEG_BITS)) u_seg_e0 (
    .clk, .we(cmd.wr_segment), .waddr(entry_index), .wdata(vertex_to),
    .raddr(sp), .rdata(sp_e));
  nppd_ram #(.WIDTH(VTX_BITS), .DEPTH(1 << SEG_BITS)) u_seg_s1 (
    .clk, .we(cmd.wr_segment), .waddr(entry_index), .wdata(vertex_from),
    .raddr(sq), .rdata(sq_s));
  nppd_ram #(.WIDTH(VTX_BITS), .DEPTH(1 << SEG_BITS)) u_seg_e1 (
    .clk, .we(cmd.wr_segment), .waddr(entry_index), .wdata(vertex_to),
    .raddr(sq), .rdata(sq_e));

  always_ff @(posedge clk) begin
    if (cmd.seg_rd) begin
      p1 <= sp_s; p2 <= sp_e; q1 <= sq_s; q2 <= sq_e;
    end
  end

  always_comb begin
    case (cmd.vtx_leg)
      LEG_P1:  vaddr = p1;
      LEG_P2:  vaddr = p2;
      LEG_Q1:  vaddr = q1;
      LEG_Q2:  vaddr = q2;
      default: vaddr = p1;
    endcase
  end

  // Drop vertex writes beyond the store.
  assign vtx_we = cmd.wr_vertex && (entry_index[SEG_BITS-1:VTX_BITS] == '0);

  nppd_ram #(.WIDTH(COORD_BITS), .DEPTH(1 << VTX_BITS)) u_vx (
    .clk, .we(vtx_we), .waddr(entry_index[VTX_BITS-1:0]),
    .wdata(x_first), .raddr(vaddr), .rdata(vx_rd));
  nppd_ram #(.WIDTH(COORD_BITS), .DEPTH(1 << VTX_BITS)) u_vy (
    .clk, .we(vtx_we), .waddr(entry_index[VTX_BITS-1:0]),
    .wdata(y_first), .raddr(vaddr), .rdata(vy_rd));

  // Vertex legs run from the first point to its endpoints, and from the
  // second segment's endpoints to the second point; distance is symmetric.
  assign same_leg_sel = cmd.leg_direct;
  assign lg  = cmd.vtx_leg;
  assign sax = same_leg_sel ? xp : ((lg == LEG_Q1 || lg == LEG_Q2) ? xq : xp);
  assign say = same_leg_sel ? yp : ((lg == LEG_Q1 || lg == LEG_Q2) ? yq : yp);
  assign sbx = same_leg_sel ? xq : vx_rd;
  assign sby = same_leg_sel ? yq : vy_rd;

  nppd_sqrt u_sqrt (
    .clk, .rst, .start(cmd.leg_start), .ax(sax), .ay(say), .bx(sbx), .by(sby),
    .done(root_done), .root);

  always_ff @(posedge clk) begin
    if (cmd.leg_save) begin
      leg_r[cmd.save_leg] <= root;
    end
  end

  always_comb begin
    case (cmd.path_sel)
      2'd0:    praddr = {q1, p1};
      2'd1:    praddr = {q2, p1};
      2'd2:    praddr = {q1, p2};
      default: praddr = {q2, p2};
    endcase
  end

  nppd_ram #(.WIDTH(DIST_BITS), .DEPTH(1 << PATH_ABITS)) u_path (
    .clk, .we(cmd.wr_path), .waddr({vertex_to, vertex_from}),
    .wdata(path_value), .raddr(praddr), .rdata(prd));

  always_ff @(posedge clk) begin
    if (cmd.path_save) begin
      pth[cmd.path_sel] <= prd;
    end
  end

  // Candidate order: p1-q1, p1-q2, p2-q1, p2-q2.
  always_comb begin
    case (sum_idx)
      2'd0:    cand = (SUM_BITS+3)'(leg_r[LEG_P1]) + (SUM_BITS+3)'(pth[0])
                      + (SUM_BITS+3)'(leg_r[LEG_Q1]);
      2'd1:    cand = (SUM_BITS+3)'(leg_r[LEG_P1]) + (SUM_BITS+3)'(pth[1])
                      + (SUM_BITS+3)'(leg_r[LEG_Q2]);
      2'd2:    cand = (SUM_BITS+3)'(leg_r[LEG_P2]) + (SUM_BITS+3)'(pth[2])
                      + (SUM_BITS+3)'(leg_r[LEG_Q1]);
      default: cand = (SUM_BITS+3)'(leg_r[LEG_P2]) + (SUM_BITS+3)'(pth[3])
                      + (SUM_BITS+3)'(leg_r[LEG_Q2]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_idx <= '0;
    end else if (cmd.cap) begin
      sum_idx <= '0;
    end else if (cmd.sum_step) begin
      sum_idx <= sum_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      best <= '1;
    end else if (cmd.sum_step) begin
      if (cand < best) best <= cand;
    end else if (cmd.leg_save && cmd.leg_direct) begin
      best <= (SUM_BITS+3)'(root);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      res_saturated <= |best[SUM_BITS+2:DIST_BITS];
      res_distance  <= (|best[SUM_BITS+2:DIST_BITS]) ? '1 : best[DIST_BITS-1:0];
    end
  end

  assign stat.same      = (sp == sq);
  assign stat.root_done = root_done;

endmodule

// File: hw/rtl/nppd_ctrl.sv
// ---------------------------------------------------------------------------
// nppd_ctrl
// Sequencer for writes and queries, plus the row and column counters.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nppd_ctrl
  import nppd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic [CNT_BITS-1:0] first_cnt,
  input  logic [CNT_BITS-1:0] second_cnt,
  output cmd_t                cmd,
  input  stat_t               stat,
  output logic                res_same,
  output logic                res_row_last,
  output logic                res_matrix_last
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEG, ST_SEGW, ST_VRD, ST_VST, ST_ROOT, ST_PATH, ST_PATHW, ST_SUM,
    ST_DIRECT, ST_DROOT, ST_LOAD
  } state_t;

  state_t              state;
  logic [1:0]          leg;
  logic [1:0]          pidx;
  logic [CNT_BITS-1:0] row_cnt, col_cnt;
  logic                rl, ml, accept, out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign rl = col_cnt == CNT_BITS'(second_cnt - 1'b1);
  assign ml = rl && (row_cnt == CNT_BITS'(first_cnt - 1'b1));

  always_comb begin
    cmd = '0;
    cmd.cap        = accept && (mode == MODE_QUERY);
    cmd.wr_vertex  = accept && (mode == MODE_VERTEX);
    cmd.wr_segment = accept && (mode == MODE_SEGMENT);
    cmd.wr_path    = accept && (mode == MODE_PATH);
    cmd.vtx_leg    = leg_t'(leg);
    cmd.save_leg   = leg_t'(leg);
    cmd.path_sel   = pidx;
    case (state)
      ST_SEG:   cmd.seg_rd = 1'b0;
      ST_SEGW:  cmd.seg_rd = 1'b1;
      ST_VST:   cmd.leg_start = 1'b1;
      ST_ROOT:  cmd.leg_save = stat.root_done;
      ST_PATHW: cmd.path_save = 1'b1;
      ST_SUM:   cmd.sum_step = 1'b1;
      ST_DIRECT: begin
        cmd.leg_start  = 1'b1;
        cmd.leg_direct = 1'b1;
      end
      ST_DROOT: begin
        cmd.leg_direct = 1'b1;
        cmd.leg_save   = stat.root_done;
      end
      // Hold the result register while the previous result waits.
      ST_LOAD:  cmd.result_load = out_free;
      default:  cmd.seg_rd = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      row_cnt   <= '0;
      col_cnt   <= '0;
      leg       <= '0;
      pidx      <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && mode == MODE_QUERY) state <= ST_SEG;
        end
        ST_SEG: state <= stat.same ? ST_DIRECT : ST_SEGW;
        ST_SEGW: begin
          leg   <= '0;
          state <= ST_VRD;
        end
        // Vertex read address is registered in the RAM during this cycle.
        ST_VRD: state <= ST_VST;
        ST_VST: state <= ST_ROOT;
        ST_ROOT: begin
          if (stat.root_done) begin
            leg <= leg + 1'b1;
            if (leg == 2'd3) begin
              pidx  <= '0;
              state <= ST_PATH;
            end else begin
              state <= ST_VRD;
            end
          end
        end
        ST_PATH: state <= ST_PATHW;
        ST_PATHW: begin
          pidx  <= pidx + 1'b1;
          state <= (pidx == 2'd3) ? ST_SUM : ST_PATH;
        end
        ST_SUM: begin
          pidx <= pidx + 1'b1;
          if (pidx == 2'd3) state <= ST_LOAD;
        end
        ST_DIRECT: state <= ST_DROOT;
        ST_DROOT:  if (stat.root_done) state <= ST_LOAD;
        ST_LOAD: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            res_same        <= stat.same;
            res_row_last    <= rl;
            res_matrix_last <= ml;
            if (ml) begin
              row_cnt <= '0;
              col_cnt <= '0;
            end else if (rl) begin
              col_cnt <= '0;
              row_cnt <= row_cnt + 1'b1;
            end else begin
              col_cnt <= col_cnt + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_ready_idle, clk, rst, !in_ready || state == ST_IDLE,
              "input taken while busy")
  `ASSERT_NEXT(a_query_busy, clk, rst, accept && mode == MODE_QUERY,
               state == ST_SEG, "query not started")
  `ASSERT_NEXT(a_out_load, clk, rst, state == ST_LOAD && out_free,
               out_valid, "result not presented")
  `ASSERT_CLK(a_ml_rl, clk, rst, !out_valid || !res_matrix_last || res_row_last,
              "matrix end without row end")

endmodule

// File: hw/rtl/network_point_pair_distance.sv
// ---------------------------------------------------------------------------
// network_point_pair_distance
// Shortest network distance between two points on a segment network.
// ---------------------------------------------------------------------------
// Usage: modes 0, 1 and 2 load vertex, segment and path stores and give no
// result; each leaves the block idle and ready. Mode 3 is a query that
// returns one transfer on the output channel with the distance and the
// row/matrix end flags. A query on one segment takes one square root; a
// query across segments takes four roots in turn on the single root unit,
// four path reads and four compare steps. The shared root unit works
// bit-serially, one result bit a cycle. The next item can be taken in the
// cycle after the result is loaded.
// The counts are set through the APB port at 0x0 and 0x4; both reset to 1.
// Reset clears the counters and the handshake state; the stores hold
// nothing until written. A result waits in its output register while the
// receiver stalls; items are still taken meanwhile, and a query that ends
// behind a waiting result holds in its last step, input not ready, until
// that register is free.
// ---------------------------------------------------------------------------
module network_point_pair_distance
  import nppd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   mode,
  input  logic [SEG_BITS-1:0]          entry_index,
  input  logic [VTX_BITS-1:0]          vertex_from,
  input  logic [VTX_BITS-1:0]          vertex_to,
  input  logic [DIST_BITS-1:0]         path_value,
  input  logic signed [COORD_BITS-1:0] x_first,
  input  logic signed [COORD_BITS-1:0] y_first,
  input  logic [SEG_BITS-1:0]          seg_first,
  input  logic signed [COORD_BITS-1:0] x_second,
  input  logic signed [COORD_BITS-1:0] y_second,
  input  logic [SEG_BITS-1:0]          seg_second,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [DIST_BITS-1:0]         distance,
  output logic                         same_segment,
  output logic                         saturated,
  output logic                         row_last,
  output logic                         matrix_last
);

  localparam logic [2:0] ADDR_FIRST  = 3'h0;
  localparam logic [2:0] ADDR_SECOND = 3'h4;

  logic [CNT_BITS-1:0] first_cnt, second_cnt;
  cmd_t                cmd;
  stat_t               stat;
  logic                wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_cnt  <= CNT_BITS'(1);
      second_cnt <= CNT_BITS'(1);
    end else if (wr) begin
      if (paddr == ADDR_FIRST)  first_cnt  <= pwdata[CNT_BITS-1:0];
      if (paddr == ADDR_SECOND) second_cnt <= pwdata[CNT_BITS-1:0];
    end
  end

  always_comb begin
    case (paddr)
      ADDR_FIRST:  prdata = 32'(first_cnt);
      ADDR_SECOND: prdata = 32'(second_cnt);
      default:     prdata = '0;
    endcase
  end

  nppd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .mode, .out_valid, .out_ready,
    .first_cnt, .second_cnt, .cmd, .stat,
    .res_same(same_segment), .res_row_last(row_last),
    .res_matrix_last(matrix_last));

  nppd_datapath u_dp (
    .clk, .rst, .cmd, .stat, .entry_index, .vertex_from, .vertex_to,
    .path_value, .x_first, .y_first, .seg_first, .x_second, .y_second,
    .seg_second, .res_distance(distance), .res_saturated(saturated));

endmodule
